// ===== design/bitmap_slot_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// bitmap_slot_allocator_defines.svh
// Assertion macros used by the slot allocator port checks. Each macro expects
// signals named clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap_slot_allocator: assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap_slot_allocator: assertion failed");

`endif

// ===== design/bsa_pkg.sv =====
// ---------------------------------------------------------------------------
// bsa_pkg
// Types and constants of the bitmap slot allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int SEGMENTS     = 8;
  localparam int WORD_BITS    = 32;
  localparam int SEG_W        = 3;
  localparam int SLOT_W       = 5;
  localparam int POOL_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int OFFSET_W     = 22;
  localparam int STRIDE_W     = 7;
  localparam int INCR_W       = 9;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int IDX_W        = SEG_W + SLOT_W;
  localparam int PROD_W       = IDX_W + STRIDE_W;
  localparam int FULL_PROD_W  = PROD_W + INCR_W;

  // request operations
  localparam logic FN_ACQUIRE = 1'b0;
  localparam logic FN_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RELEASE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_STRIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMP_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_INCR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMP_INCR   = 2'd3;

  typedef struct packed {
    logic              func;
    logic [POOL_W-1:0] release_pool;
    logic [SEG_W-1:0]  release_segment;
    logic [SLOT_W-1:0] release_slot;
  } bsa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POOL_W-1:0]   pool;
    logic [SEG_W-1:0]    segment;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] buffer_offset;
    logic [OFFSET_W-1:0] sampler_offset;
  } bsa_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic lookup;
    logic modify;
    logic finish;
  } bsa_cmd_t;

endpackage

`default_nettype wire

// ===== design/bitmap_slot_allocator.sv =====
// ---------------------------------------------------------------------------
// bitmap_slot_allocator
// First-free slot allocator over descriptor pool occupancy bitmaps.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with in_data (func, release_pool,
//   release_segment, release_slot); a request is taken at a clock edge with
//   in_valid high and in_stall low. Every request yields exactly one result
//   on out_valid/out_stall with out_data (status, pool, segment, slot and the
//   two heap byte offsets).
//   The result passes the lookup, the read-modify-write of the bitmap word
//   and the second offset multiply before it is registered.
//   One request is in flight at a time, set by the bitmap RAM's
//   read-modify-write and the two-stage offset multipliers; in_stall stays
//   high while a request is in flight.
//   A result waiting in the output register does not block the next request;
//   only the final step holds while out_stall keeps the previous result.
//   Reset (rst_n low, synchronous): all slots free, one pool open, default
//   strides and increments. Per-word valid bits stand in for a RAM clear, so
//   no clearing pass runs and requests are taken right after reset.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) must go in only
//   while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator #(
  parameter int MAX_POOLS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bsa_pkg::bsa_req_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bsa_pkg::bsa_rsp_t                  out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bsa_pkg::CFG_W-1:0]     cfg_wdata
);
  import bsa_pkg::*;

  bsa_cmd_t cmd;

  // sequence each request through lookup, update and finish
  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // hold bitmaps, search for a free word, compute the heap offsets
  bsa_dpath #(
    .MAX_POOLS (MAX_POOLS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/bsa_ram.sv =====
// ---------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/bsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: capture, word lookup, read-modify-write, offset finish.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bsa_pkg::bsa_cmd_t      cmd
);
  import bsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_MOD,
    S_MUL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;

  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.lookup  = (state_r == S_LOOK);
  assign cmd.modify  = (state_r == S_MOD);
  assign cmd.finish  = (state_r == S_MUL) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK:  state_nxt = S_MOD;
      S_MOD:   state_nxt = S_MUL;
      S_MUL: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/bsa_dpath.sv =====
// ---------------------------------------------------------------------------
// bsa_dpath
// Occupancy storage, free-word search, bit update and offset multipliers.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_dpath #(
  parameter int MAX_POOLS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bsa_pkg::bsa_cmd_t                cmd,
  input  wire bsa_pkg::bsa_req_t                in_data,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bsa_pkg::CFG_W-1:0]        cfg_wdata,
  output bsa_pkg::bsa_rsp_t                     out_data
);
  import bsa_pkg::*;

  localparam int WORDS  = MAX_POOLS * SEGMENTS;
  localparam int AW     = $clog2(WORDS);
  localparam int OPEN_W = $clog2(MAX_POOLS + 1);

  // configuration
  logic [STRIDE_W-1:0] buf_stride_r, smp_stride_r;
  logic [INCR_W-1:0]   buf_incr_r, smp_incr_r;

  // request and per-word state
  bsa_req_t          req_r;
  logic [AW-1:0]     addr_r;
  logic              hit_r;
  logic              rd_valid_r;
  logic [WORDS-1:0]  valid_r;
  logic [WORDS-1:0]  full_r;
  logic [OPEN_W-1:0] open_r;

  // result staging
  logic [STATUS_W-1:0] status_r;
  logic [POOL_W-1:0]   pool_r;
  logic [SEG_W-1:0]    seg_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PROD_W-1:0]   prod_b_r, prod_s_r;
  bsa_rsp_t            out_r;

  // lookup
  logic [OPEN_W-1:0] limit;
  logic              free_hit;
  logic [AW-1:0]     free_addr;
  logic              rel_ok;
  logic              look_hit;
  logic [AW-1:0]     look_addr;

  // modify
  logic [WORD_BITS-1:0] ram_q;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] wdata;
  logic [SLOT_W-1:0]    clear_pos;
  logic [SLOT_W-1:0]    bit_pos;
  logic                 is_release;
  logic                 grant;
  logic                 ram_we;
  logic [SEG_W-1:0]     seg_sel;
  logic [POOL_W-1:0]    pool_sel;
  logic [IDX_W-1:0]     idx;

  // Open pools plus the next one to open take part in the search; the
  // next pool's words are still all free, so its first slot wins there.
  always_comb begin
    limit     = (open_r < OPEN_W'(MAX_POOLS)) ? open_r + 1'b1 : open_r;
    free_hit  = 1'b0;
    free_addr = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if ((i / SEGMENTS) < int'(limit) && !full_r[i]) begin
        free_hit  = 1'b1;
        free_addr = AW'(i);
      end
    end
    rel_ok = int'(req_r.release_pool) < MAX_POOLS;
    if (req_r.func == FN_RELEASE) begin
      look_hit  = rel_ok;
      look_addr = rel_ok ? AW'({req_r.release_pool, req_r.release_segment}) : '0;
    end else begin
      look_hit  = free_hit;
      look_addr = free_addr;
    end
  end

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (wdata),
    .raddr (look_addr),
    .rdata (ram_q)
  );

  always_comb begin
    word       = rd_valid_r ? ram_q : '0;
    clear_pos  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        clear_pos = SLOT_W'(i);
      end
    end
    is_release = (req_r.func == FN_RELEASE);
    bit_pos    = is_release ? req_r.release_slot : clear_pos;
    mask       = WORD_BITS'(1) << bit_pos;
    wdata      = is_release ? (word & ~mask) : (word | mask);
    ram_we     = cmd.modify && hit_r;
    grant      = !is_release && hit_r;
    seg_sel    = addr_r[SEG_W-1:0];
    pool_sel   = POOL_W'(addr_r >> SEG_W);
    idx        = grant ? {seg_sel, clear_pos} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_stride_r <= STRIDE_W'(16);
      smp_stride_r <= STRIDE_W'(8);
      buf_incr_r   <= INCR_W'(32);
      smp_incr_r   <= INCR_W'(32);
      valid_r      <= '0;
      full_r       <= '0;
      open_r       <= OPEN_W'(1);
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BUF_STRIDE: buf_stride_r <= cfg_wdata[STRIDE_W-1:0];
          CFG_SMP_STRIDE: smp_stride_r <= cfg_wdata[STRIDE_W-1:0];
          CFG_BUF_INCR:   buf_incr_r   <= cfg_wdata[INCR_W-1:0];
          CFG_SMP_INCR:   smp_incr_r   <= cfg_wdata[INCR_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        valid_r[addr_r] <= 1'b1;
        full_r[addr_r]  <= &wdata;
      end
      if (cmd.modify && grant && int'(pool_sel) == int'(open_r)) begin
        open_r <= open_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.lookup) begin
      addr_r     <= look_addr;
      hit_r      <= look_hit;
      rd_valid_r <= valid_r[look_addr];
    end
    if (cmd.modify) begin
      status_r <= is_release ? ST_RELEASE : (hit_r ? ST_GRANT : ST_FULL);
      pool_r   <= grant ? pool_sel : '0;
      seg_r    <= grant ? seg_sel : '0;
      slot_r   <= grant ? clear_pos : '0;
      prod_b_r <= PROD_W'(idx) * PROD_W'(buf_stride_r);
      prod_s_r <= PROD_W'(idx) * PROD_W'(smp_stride_r);
    end
    if (cmd.finish) begin
      out_r.status         <= status_r;
      out_r.pool           <= pool_r;
      out_r.segment        <= seg_r;
      out_r.slot           <= slot_r;
      out_r.buffer_offset  <= OFFSET_W'(FULL_PROD_W'(prod_b_r) * FULL_PROD_W'(buf_incr_r));
      out_r.sampler_offset <= OFFSET_W'(FULL_PROD_W'(prod_s_r) * FULL_PROD_W'(smp_incr_r));
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== design/bsa_checker.sv =====
// ---------------------------------------------------------------------------
// bsa_port_checks
// Port-level checks of the slot allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitmap_slot_allocator_defines.svh"

module bsa_port_checks (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire bsa_pkg::bsa_rsp_t out_data
);
  import bsa_pkg::*;

  // a held result stays put
  `BSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one request in flight at a time
  `BSA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // release and full results carry no slot or offset
  `BSA_ASSERT_NOW(a_nongrant_zero, out_valid && out_data.status != ST_GRANT,
    out_data.pool == '0 && out_data.segment == '0 && out_data.slot == '0 &&
    out_data.buffer_offset == '0 && out_data.sampler_offset == '0)

  // only defined status codes leave the block
  `BSA_ASSERT_NOW(a_status_code, out_valid,
    out_data.status == ST_GRANT || out_data.status == ST_RELEASE ||
    out_data.status == ST_FULL)

endmodule

bind bitmap_slot_allocator bsa_port_checks u_bsa_port_checks (.*);

`default_nettype wire

// ===== sim/bsa_checker.sv =====
// ---------------------------------------------------------------------------
// bsa_checker
// Watches the request, result and register ports of the slot allocator,
// keeps its own copy of the occupancy bitmaps and heap registers, predicts
// the result of every accepted request and compares results in order.
// ---------------------------------------------------------------------------
module bsa_checker #(
  parameter int MAX_POOLS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  bsa_pkg::bsa_req_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  bsa_pkg::bsa_rsp_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsa_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            err_count,
  output int                            pending_cnt,
  output int                            grant_cnt,
  output int                            release_cnt,
  output int                            full_cnt
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] occ_map [MAX_POOLS*SEGMENTS];
  int unsigned          pools_open;
  logic [STRIDE_W-1:0]  buf_stride;
  logic [STRIDE_W-1:0]  smp_stride;
  logic [INCR_W-1:0]    buf_incr;
  logic [INCR_W-1:0]    smp_incr;

  bsa_rsp_t due_rsp [$];
  bsa_rsp_t want;

  function automatic logic [OFFSET_W-1:0] heap_offset(int unsigned idx,
                                                      logic [STRIDE_W-1:0] stride,
                                                      logic [INCR_W-1:0] incr);
    int unsigned prod;
    prod = idx * stride * incr;
    return prod[OFFSET_W-1:0];
  endfunction

  function automatic bsa_rsp_t grant_rsp(int unsigned p, int unsigned s, int unsigned b);
    bsa_rsp_t    r;
    int unsigned idx;
    idx = s * WORD_BITS + b;
    r = '0;
    r.status         = ST_GRANT;
    r.pool           = POOL_W'(p);
    r.segment        = SEG_W'(s);
    r.slot           = SLOT_W'(b);
    r.buffer_offset  = heap_offset(idx, buf_stride, buf_incr);
    r.sampler_offset = heap_offset(idx, smp_stride, smp_incr);
    return r;
  endfunction

  // Apply one request to the bitmap copy and return the result it must give.
  function automatic bsa_rsp_t serve_request(bsa_req_t rq);
    bsa_rsp_t    r;
    int unsigned w;
    r = '0;
    if (rq.func == FN_RELEASE) begin
      r.status = ST_RELEASE;
      if (int'(rq.release_pool) < MAX_POOLS)
        occ_map[rq.release_pool*SEGMENTS + rq.release_segment][rq.release_slot] = 1'b0;
      return r;
    end
    for (int p = 0; p < int'(pools_open); p++) begin
      for (int s = 0; s < SEGMENTS; s++) begin
        w = p * SEGMENTS + s;
        if (occ_map[w] != '1) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (!occ_map[w][b]) begin
              occ_map[w][b] = 1'b1;
              return grant_rsp(p, s, b);
            end
          end
        end
      end
    end
    if (int'(pools_open) < MAX_POOLS) begin
      occ_map[pools_open*SEGMENTS][0] = 1'b1;
      r = grant_rsp(pools_open, 0, 0);
      pools_open++;
      return r;
    end
    r.status = ST_FULL;
    return r;
  endfunction

  task automatic compare_rsp(bsa_rsp_t exp_r, bsa_rsp_t got);
    if (got.status !== exp_r.status) begin
      $error("status mismatch: expected %0d, got %0d", exp_r.status, got.status);
      err_count++;
    end
    if (got.pool !== exp_r.pool) begin
      $error("pool mismatch: expected %0d, got %0d", exp_r.pool, got.pool);
      err_count++;
    end
    if (got.segment !== exp_r.segment) begin
      $error("segment mismatch: expected %0d, got %0d", exp_r.segment, got.segment);
      err_count++;
    end
    if (got.slot !== exp_r.slot) begin
      $error("slot mismatch: expected %0d, got %0d", exp_r.slot, got.slot);
      err_count++;
    end
    if (got.buffer_offset !== exp_r.buffer_offset) begin
      $error("buffer_offset mismatch: expected %0d, got %0d",
             exp_r.buffer_offset, got.buffer_offset);
      err_count++;
    end
    if (got.sampler_offset !== exp_r.sampler_offset) begin
      $error("sampler_offset mismatch: expected %0d, got %0d",
             exp_r.sampler_offset, got.sampler_offset);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (occ_map[i]) occ_map[i] = '0;
      pools_open = 1;
      buf_stride = 7'd16;
      smp_stride = 7'd8;
      buf_incr   = 9'd32;
      smp_incr   = 9'd32;
      due_rsp.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_rsp.size() == 0) begin
          $error("result with no request outstanding: status %0d", out_data.status);
          err_count++;
        end else begin
          want = due_rsp.pop_front();
          case (want.status)
            ST_GRANT:   grant_cnt++;
            ST_RELEASE: release_cnt++;
            default:    full_cnt++;
          endcase
          compare_rsp(want, out_data);
        end
      end
      if (in_valid && !in_stall)
        due_rsp = {due_rsp, serve_request(in_data)};
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BUF_STRIDE: buf_stride = cfg_wdata[STRIDE_W-1:0];
          CFG_SMP_STRIDE: smp_stride = cfg_wdata[STRIDE_W-1:0];
          CFG_BUF_INCR:   buf_incr   = cfg_wdata[INCR_W-1:0];
          CFG_SMP_INCR:   smp_incr   = cfg_wdata[INCR_W-1:0];
          default: ;
        endcase
      end
    end
    pending_cnt = due_rsp.size();
  end

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Top of the slot allocator testbench. Drives a short directed sequence and
// then random acquire/release requests over several heap register settings,
// fills every pool until the block reports full, and throttles both channels
// at random. The checker beside the block predicts and compares results.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int MAX_POOLS      = 4;
  localparam int DRAIN_CYCLES   = 12;   // settle time after the last predicted result
  localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
  localparam int FILL_CAP       = 900;  // bound on the fill-up phase

  bit                   clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  bsa_req_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  bsa_rsp_t             out_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int err_count, pending_cnt, grant_cnt, release_cnt, full_cnt;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;
  int          settings_used;
  int          fill_reqs;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_slot_allocator #(.MAX_POOLS(MAX_POOLS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bsa_checker #(.MAX_POOLS(MAX_POOLS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .err_count   (err_count),
    .pending_cnt (pending_cnt),
    .grant_cnt   (grant_cnt),
    .release_cnt (release_cnt),
    .full_cnt    (full_cnt)
  );

  // Build one request from its fields.
  function automatic bsa_req_t make_req(logic fn, int unsigned p, int unsigned s,
                                        int unsigned b);
    bsa_req_t rq;
    rq.func            = fn;
    rq.release_pool    = POOL_W'(p);
    rq.release_segment = SEG_W'(s);
    rq.release_slot    = SLOT_W'(b);
    return rq;
  endfunction

  // Random request: the release fields always carry random content, even on
  // an acquire where the block ignores them. Half the releases are forced to
  // pool 0, which fills first, so most of those free a slot that is really taken.
  function automatic bsa_req_t random_request(int unsigned acquire_pct);
    bsa_req_t rq;
    rq = make_req(FN_RELEASE, $urandom_range(3), $urandom_range(7), $urandom_range(31));
    if ($urandom_range(99) < acquire_pct)
      rq.func = FN_ACQUIRE;
    else if ($urandom_range(1) == 0)
      rq.release_pool = '0;
    return rq;
  endfunction

  // Offer one request; enter and leave at a falling edge. Keep in_valid high
  // when the next request follows without a gap.
  task automatic push_request(bsa_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Write all four heap registers on consecutive cycles.
  task automatic load_config(logic [CFG_W-1:0] bs, logic [CFG_W-1:0] ss,
                             logic [CFG_W-1:0] bi, logic [CFG_W-1:0] si);
    write_reg(CFG_BUF_STRIDE, bs);
    write_reg(CFG_SMP_STRIDE, ss);
    write_reg(CFG_BUF_INCR, bi);
    write_reg(CFG_SMP_INCR, si);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Receiver: stall at random, and hard while a hold-off is on.
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    hold_off      = 1'b0;
    settings_used = 1;
    send_idle_pct = 23;
    recv_idle_pct = 80;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset register values: first grants, reuse of a freed slot,
    // release of a free slot and of pools that are not open yet, field
    // extremes, and an acquire whose release fields are all ones.
    push_request(make_req(FN_ACQUIRE, 0, 0, 0));
    push_request(make_req(FN_ACQUIRE, 0, 0, 0));
    push_request(make_req(FN_RELEASE, 0, 0, 0));
    push_request(make_req(FN_ACQUIRE, 0, 0, 0));
    push_request(make_req(FN_RELEASE, 0, 0, 31));
    push_request(make_req(FN_RELEASE, 3, 7, 31));
    push_request(make_req(FN_RELEASE, 1, 4, 15));
    push_request(make_req(FN_ACQUIRE, 3, 7, 31));
    push_request(make_req(FN_ACQUIRE, 2, 5, 10));
    push_request(make_req(FN_RELEASE, 0, 0, 1));
    push_request(make_req(FN_ACQUIRE, 1, 2, 21));
    push_request(make_req(FN_ACQUIRE, 0, 0, 0));
    push_request(make_req(FN_RELEASE, 2, 3, 16));
    push_request(make_req(FN_ACQUIRE, 0, 0, 0));
    wait_drained();

    // Smallest strides and increments; sender mostly busy, receiver lazy.
    load_config(1, 1, 1, 1);
    repeat (260) push_request(random_request(88));
    wait_drained();

    // Largest in-range values; swap the idling of the two sides.
    send_idle_pct = 80;
    recv_idle_pct = 23;
    load_config(64, 64, 256, 256);
    repeat (260) push_request(random_request(94));
    wait_drained();

    // Out-of-range values: buffer offset wraps, sampler stride zero.
    // No idling; hold the receiver off for a long stretch meanwhile so the
    // block backs up and stalls its input. Fill every pool until full.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(127, 0, 511, 256);
    fork
      begin
        repeat (40) @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    fill_reqs = 0;
    while (full_cnt < 6 && fill_reqs < FILL_CAP) begin
      push_request(random_request(97));
      fill_reqs++;
    end
    wait_drained();

    // Random register contents (upper bits of the stride writes included);
    // churn the full pools with releases and regrants, still with no idling.
    load_config(CFG_W'($urandom_range(511)), CFG_W'($urandom_range(511)),
                CFG_W'($urandom_range(511)), CFG_W'($urandom_range(511)));
    repeat (40) push_request(random_request(55));
    wait_drained();

    $display("Covered %0d grants, %0d releases and %0d pool-full answers",
             grant_cnt, release_cnt, full_cnt);
    $display("over %0d heap register settings, with a %0d-cycle receiver hold-off.",
             settings_used, HOLD_CYCLES);
    if (err_count == 0 && pending_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
